// ----- rtl/matrix_multiply_engine_defines.svh -----
// Assertion macros used by the matrix multiply engine top level.
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define MME_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: invariant failed");
// Condition in one cycle implies a consequence in the following cycle.
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: sequencing check failed");
`else
`define MME_ASSERT(label, clk, rst_n, prop)
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/mme_pkg.sv -----
// Shared constants and datapath control types for the matrix multiply engine.
package mme_pkg;

  localparam int MAX_INNER   = 16;
  localparam int MAX_COLS    = 16;
  localparam int DATA_W      = 16;
  localparam int STORE_DEPTH = MAX_INNER * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IPOS_W      = $clog2(MAX_INNER);
  localparam int CPOS_W      = $clog2(MAX_COLS);
  localparam int INNER_W     = $clog2(MAX_INNER + 1);
  localparam int COLS_W      = $clog2(MAX_COLS + 1);
  localparam int LIM_W       = INNER_W + COLS_W;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = 48;
  localparam int RES_W       = 32;
  localparam int ROW_W       = 8;
  localparam int COL_OUT_W   = 4;

  localparam int ROWS_CFG_W  = 8;
  localparam int INNER_CFG_W = 5;
  localparam int COLS_CFG_W  = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic OP_LOAD_B   = 1'b0;
  localparam logic OP_STREAM_A = 1'b1;

  typedef struct packed {
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CPOS_W-1:0]        rd_col;
    logic signed [DATA_W-1:0] a_value;
    logic                     clear_all;
    logic                     clear_one;
    logic [CPOS_W-1:0]        emit_col;
  } mac_ctrl_t;

  typedef struct packed {
    logic                    busy;
    logic signed [ACC_W-1:0] emit_acc;
  } mac_stat_t;

endpackage

// ----- rtl/mme_if.sv -----
// Valid/ready stream interfaces for the engine's input and result channels.
interface mme_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic signed [mme_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface mme_out_if;
  logic                               valid;
  logic                               ready;
  logic [mme_pkg::COL_OUT_W-1:0]      column_index;
  logic [mme_pkg::ROW_W-1:0]          row_index;
  logic signed [mme_pkg::RES_W-1:0]   product_sum;
  logic                               saturated;
  logic                               last_in_row;
  logic                               matrix_done;

  modport source (output valid, output column_index, output row_index,
                  output product_sum, output saturated, output last_in_row,
                  output matrix_done, input ready);
  modport sink (input valid, input column_index, input row_index,
                input product_sum, input saturated, input last_in_row,
                input matrix_done, output ready);
endinterface

// ----- rtl/matrix_multiply_engine.sv -----
// Top level of the fixed-point matrix multiply engine: sequencer, configuration and result register.
//
//   channel      direction  handshake          payload
//   in_stream    in         valid/ready        operation, value (Q8.8)
//   out_stream   out        valid/ready        column_index, row_index, product_sum,
//                                              saturated, last_in_row, matrix_done
//   cfg_*        in         write enable only  cfg_index, cfg_data
//
// A right-matrix load is written to the store as it is accepted. A left-matrix element is taken
// only while idle: one multiply-accumulate unit walks the columns one per cycle behind a registered
// store read, then drains two pipeline stages. After the last element of a row, the results
// go to the output register, one per cycle while the sink keeps up.
// Reset is synchronous on rst_n and leaves the right-matrix store unwritten.
// Output back-pressure stalls only the emission of results; the input is refused meanwhile.
module matrix_multiply_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mme_pkg::CFG_DATA_W-1:0]    cfg_data,
  mme_in_if.sink                            in_stream,
  mme_out_if.source                         out_stream
);

`include "matrix_multiply_engine_defines.svh"

  localparam int DATA_W      = mme_pkg::DATA_W;
  localparam int ADDR_W      = mme_pkg::ADDR_W;
  localparam int IPOS_W      = mme_pkg::IPOS_W;
  localparam int CPOS_W      = mme_pkg::CPOS_W;
  localparam int INNER_W     = mme_pkg::INNER_W;
  localparam int COLS_W      = mme_pkg::COLS_W;
  localparam int LIM_W       = mme_pkg::LIM_W;
  localparam int ACC_W       = mme_pkg::ACC_W;
  localparam int RES_W       = mme_pkg::RES_W;
  localparam int ROW_W       = mme_pkg::ROW_W;
  localparam int COL_OUT_W   = mme_pkg::COL_OUT_W;
  localparam int ROWS_CFG_W  = mme_pkg::ROWS_CFG_W;
  localparam int INNER_CFG_W = mme_pkg::INNER_CFG_W;
  localparam int COLS_CFG_W  = mme_pkg::COLS_CFG_W;
  localparam int MAX_INNER   = mme_pkg::MAX_INNER;
  localparam int MAX_COLS    = mme_pkg::MAX_COLS;

  localparam logic [ROWS_CFG_W-1:0]  ROWS_RESET  = ROWS_CFG_W'(1);
  localparam logic [INNER_CFG_W-1:0] INNER_RESET = INNER_CFG_W'(16);
  localparam logic [COLS_CFG_W-1:0]  COLS_RESET  = COLS_CFG_W'(16);
  localparam logic [RES_W-1:0]       RES_MAX     = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0]       RES_MIN     = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef enum logic [mme_pkg::CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_reg_t;

  state_t                   state_r, state_nxt;
  logic [ROWS_CFG_W-1:0]    rows_a_r, rows_a_nxt;
  logic [INNER_CFG_W-1:0]   inner_dim_r, inner_dim_nxt;
  logic [COLS_CFG_W-1:0]    cols_b_r, cols_b_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [ADDR_W-1:0]        base_r, base_nxt;
  logic [CPOS_W-1:0]        col_r, col_nxt;
  logic                     row_done_r, row_done_nxt;
  logic [ADDR_W-1:0]        load_pos_r, load_pos_nxt;
  logic [IPOS_W-1:0]        inner_pos_r, inner_pos_nxt;
  logic [ROW_W-1:0]         row_pos_r, row_pos_nxt;
  logic [CPOS_W-1:0]        emit_col_r, emit_col_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [COL_OUT_W-1:0]     out_col_r, out_col_nxt;
  logic [ROW_W-1:0]         out_row_r, out_row_nxt;
  logic [RES_W-1:0]         out_sum_r, out_sum_nxt;
  logic                     out_sat_r, out_sat_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_done_r, out_done_nxt;

  logic [ROW_W-1:0]         rows_eff;
  logic [INNER_W-1:0]       inner_eff;
  logic [COLS_W-1:0]        cols_eff;
  logic [LIM_W-1:0]         store_limit;
  logic [IPOS_W+COLS_W-1:0] base_prod;
  logic                     load_wrap;
  logic                     inner_last;
  logic                     col_last;
  logic                     emit_last;
  logic                     row_last;
  logic                     in_accept;
  logic                     out_free;
  logic                     sum_fits;
  logic                     restart;

  mme_pkg::mac_ctrl_t       mac_ctrl;
  mme_pkg::mac_stat_t       mac_stat;

  mme_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (mac_ctrl),
    .stat (mac_stat)
  );

  // Zero in a dimension register means one; oversized inner and column counts clamp.
  always_comb begin
    rows_eff = (rows_a_r == '0) ? ROW_W'(1) : ROW_W'(rows_a_r);
    if (inner_dim_r == '0) begin
      inner_eff = INNER_W'(1);
    end else if (32'(inner_dim_r) > MAX_INNER) begin
      inner_eff = INNER_W'(MAX_INNER);
    end else begin
      inner_eff = INNER_W'(inner_dim_r);
    end
    if (cols_b_r == '0) begin
      cols_eff = COLS_W'(1);
    end else if (32'(cols_b_r) > MAX_COLS) begin
      cols_eff = COLS_W'(MAX_COLS);
    end else begin
      cols_eff = COLS_W'(cols_b_r);
    end
  end

  assign store_limit = LIM_W'(inner_eff) * LIM_W'(cols_eff);
  assign base_prod   = (IPOS_W+COLS_W)'(inner_pos_r) * (IPOS_W+COLS_W)'(cols_eff);
  assign load_wrap   = (LIM_W'(load_pos_r) + 1'b1) == store_limit;
  assign inner_last  = (INNER_W'(inner_pos_r) + 1'b1) == inner_eff;
  assign col_last    = (COLS_W'(col_r) + 1'b1) == cols_eff;
  assign emit_last   = (COLS_W'(emit_col_r) + 1'b1) == cols_eff;
  assign row_last    = ((ROW_W+1)'(row_pos_r) + 1'b1) >= (ROW_W+1)'(rows_eff);
  assign in_accept   = in_stream.valid && (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_stream.ready;

  // The sum fits when every bit above the result's sign bit repeats the sign.
  assign sum_fits = (mac_stat.emit_acc[ACC_W-1:RES_W-1] == '0) ||
                    (mac_stat.emit_acc[ACC_W-1:RES_W-1] == '1);

  always_comb begin
    state_nxt     = state_r;
    rows_a_nxt    = rows_a_r;
    inner_dim_nxt = inner_dim_r;
    cols_b_nxt    = cols_b_r;
    value_nxt     = value_r;
    base_nxt      = base_r;
    col_nxt       = col_r;
    row_done_nxt  = row_done_r;
    load_pos_nxt  = load_pos_r;
    inner_pos_nxt = inner_pos_r;
    row_pos_nxt   = row_pos_r;
    emit_col_nxt  = emit_col_r;
    out_valid_nxt = out_valid_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_sum_nxt   = out_sum_r;
    out_sat_nxt   = out_sat_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    restart       = 1'b0;

    mac_ctrl           = '0;
    mac_ctrl.wr_addr   = load_pos_r;
    mac_ctrl.wr_data   = in_stream.value;
    mac_ctrl.rd_addr   = base_r + ADDR_W'(col_r);
    mac_ctrl.rd_col    = col_r;
    mac_ctrl.a_value   = value_r;
    mac_ctrl.emit_col  = emit_col_r;

    if (out_valid_r && out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_stream.operation == mme_pkg::OP_LOAD_B) begin
            mac_ctrl.wr_en = 1'b1;
            load_pos_nxt   = load_wrap ? '0 : load_pos_r + 1'b1;
          end else begin
            value_nxt     = in_stream.value;
            base_nxt      = ADDR_W'(base_prod);
            col_nxt       = '0;
            row_done_nxt  = inner_last;
            inner_pos_nxt = inner_last ? '0 : inner_pos_r + 1'b1;
            state_nxt     = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        mac_ctrl.rd_en = 1'b1;
        if (col_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!mac_stat.busy) begin
          emit_col_nxt = '0;
          state_nxt    = row_done_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          mac_ctrl.clear_one = 1'b1;
          out_valid_nxt = 1'b1;
          out_col_nxt   = COL_OUT_W'(emit_col_r);
          out_row_nxt   = row_pos_r;
          out_sum_nxt   = sum_fits ? mac_stat.emit_acc[RES_W-1:0] :
                          (mac_stat.emit_acc[ACC_W-1] ? RES_MIN : RES_MAX);
          out_sat_nxt   = !sum_fits;
          out_last_nxt  = emit_last;
          out_done_nxt  = emit_last && row_last;
          if (emit_last) begin
            row_pos_nxt = row_last ? '0 : row_pos_r + 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            emit_col_nxt = emit_col_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A register write restarts the product; unknown indexes are ignored.
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROWS_A: begin
          rows_a_nxt = cfg_data[ROWS_CFG_W-1:0];
          restart    = 1'b1;
        end
        REG_INNER_DIM: begin
          inner_dim_nxt = cfg_data[INNER_CFG_W-1:0];
          restart       = 1'b1;
        end
        REG_COLS_B: begin
          cols_b_nxt = cfg_data[COLS_CFG_W-1:0];
          restart    = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
    if (restart) begin
      load_pos_nxt       = '0;
      inner_pos_nxt      = '0;
      row_pos_nxt        = '0;
      mac_ctrl.clear_all = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_a_r    <= ROWS_RESET;
      inner_dim_r <= INNER_RESET;
      cols_b_r    <= COLS_RESET;
      load_pos_r  <= '0;
      inner_pos_r <= '0;
      row_pos_r   <= '0;
      col_r       <= '0;
      emit_col_r  <= '0;
      row_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_a_r    <= rows_a_nxt;
      inner_dim_r <= inner_dim_nxt;
      cols_b_r    <= cols_b_nxt;
      load_pos_r  <= load_pos_nxt;
      inner_pos_r <= inner_pos_nxt;
      row_pos_r   <= row_pos_nxt;
      col_r       <= col_nxt;
      emit_col_r  <= emit_col_nxt;
      row_done_r  <= row_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r    <= value_nxt;
    base_r     <= base_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_sum_r  <= out_sum_nxt;
    out_sat_r  <= out_sat_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign in_stream.ready         = (state_r == ST_IDLE);
  assign out_stream.valid        = out_valid_r;
  assign out_stream.column_index = out_col_r;
  assign out_stream.row_index    = out_row_r;
  assign out_stream.product_sum  = out_sum_r;
  assign out_stream.saturated    = out_sat_r;
  assign out_stream.last_in_row  = out_last_r;
  assign out_stream.matrix_done  = out_done_r;

  `MME_ASSERT(a_load_pos_in_range, clk, rst_n, (LIM_W'(load_pos_r) < store_limit))
  `MME_ASSERT(a_positions_in_range, clk, rst_n, ((INNER_W'(inner_pos_r) < inner_eff) && (row_pos_r < rows_eff)))
  `MME_ASSERT_NEXT(a_drain_waits_for_mac, clk, rst_n, (state_r == ST_DRAIN && mac_stat.busy), (state_r == ST_DRAIN))
  `MME_ASSERT_NEXT(a_emit_fills_output, clk, rst_n, (state_r == ST_EMIT && out_free && !cfg_we), out_valid_r)
  `MME_ASSERT(a_done_on_row_end, clk, rst_n, (!out_valid_r || !out_done_r || out_last_r))

endmodule

// ----- rtl/mme_mac.sv -----
// Right-matrix store and the shared multiply-accumulate unit with column accumulators.
module mme_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  mme_pkg::mac_ctrl_t ctrl,
  output mme_pkg::mac_stat_t stat
);

  localparam int DATA_W      = mme_pkg::DATA_W;
  localparam int STORE_DEPTH = mme_pkg::STORE_DEPTH;
  localparam int CPOS_W      = mme_pkg::CPOS_W;
  localparam int PROD_W      = mme_pkg::PROD_W;
  localparam int ACC_W       = mme_pkg::ACC_W;
  localparam int MAX_COLS    = mme_pkg::MAX_COLS;

  logic signed [DATA_W-1:0] store_r [STORE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r [MAX_COLS];
  logic                     v1_r;
  logic                     v2_r;
  logic [CPOS_W-1:0]        col1_r;
  logic [CPOS_W-1:0]        col2_r;

  // Store port: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      store_r[ctrl.wr_addr] <= ctrl.wr_data;
    end
    rd_data_r <= store_r[ctrl.rd_addr];
  end

  // Multiply stage, then accumulate into the column carried along with it.
  always_ff @(posedge clk) begin
    prod_r <= ctrl.a_value * rd_data_r;
    col1_r <= ctrl.rd_col;
    col2_r <= col1_r;
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.rd_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear_all) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (ctrl.clear_one) begin
      acc_r[ctrl.emit_col] <= '0;
    end else if (v2_r) begin
      acc_r[col2_r] <= acc_r[col2_r] + ACC_W'(prod_r);
    end
  end

  assign stat.busy     = v1_r | v2_r;
  assign stat.emit_acc = acc_r[ctrl.emit_col];

endmodule
